@@ rtl/pwts_pkg.sv @@
// Shared types and constants for the perspective world-to-screen block.
// Used by pwts_div_cell, pwts_divider and perspective_world_to_screen.
package pwts_pkg;

  localparam int COEF_SLOT   = 16;
  localparam int COEF_FRAC   = 12;
  localparam int COORD_FRAC  = 8;
  localparam int DIM_W       = 14;
  localparam int OUT_W       = 20;
  localparam int W_VIS_MIN   = 1049;
  localparam int QUO_W       = 21;                  // quotient bits kept (value <= 2^20)
  localparam int DIV_STEPS   = QUO_W;

  typedef enum logic [2:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_W  = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
    logic zx;
    logic zy;
  } side_t;

endpackage

@@ rtl/pwts_div_cell.sv @@
// One restoring-division cell: retires one quotient bit per cycle while en is high and hands
// its partial remainder, quotient and denominator to the next cell.
// Depends on pwts_pkg.
module pwts_div_cell #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 60,
  parameter int BIT   = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [pwts_pkg::QUO_W-1:0] quo_i,
  output logic [NUM_W-1:0] num_o,
  output logic [DEN_W-1:0] den_o,
  output logic [pwts_pkg::QUO_W-1:0] quo_o
);
  import pwts_pkg::*;

  logic [NUM_W+BIT:0] shifted;
  logic               take;
  logic [NUM_W-1:0]   num_nxt;
  logic [QUO_W-1:0]   quo_nxt;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [QUO_W-1:0]   quo_r;

  always_comb begin
    shifted = (NUM_W+BIT+1)'(den_i) << BIT;
    take    = ({1'b0, num_i} >= shifted[NUM_W:0]) && (shifted[NUM_W+BIT:NUM_W] == '0);
    num_nxt = take ? (num_i - shifted[NUM_W-1:0]) : num_i;
    quo_nxt = quo_i;
    quo_nxt[BIT] = take;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      den_r <= den_i;
      quo_r <= quo_nxt;
    end
  end

  assign num_o = num_r;
  assign den_o = den_r;
  assign quo_o = quo_r;
endmodule

@@ rtl/pwts_divider.sv @@
// Chain of division cells for one screen axis.
// Depends on pwts_pkg and pwts_div_cell.
module pwts_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 60
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [pwts_pkg::QUO_W-1:0] quo_o,
  output logic             round_o
);
  import pwts_pkg::*;

  logic [NUM_W-1:0] num_c [DIV_STEPS+1];
  logic [DEN_W-1:0] den_c [DIV_STEPS+1];
  logic [QUO_W-1:0] quo_c [DIV_STEPS+1];

  assign num_c[0] = num_i;
  assign den_c[0] = den_i;
  assign quo_c[0] = '0;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    pwts_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BIT(DIV_STEPS-1-g)) u_cell (
      .clk(clk), .en(en),
      .num_i(num_c[g]), .den_i(den_c[g]), .quo_i(quo_c[g]),
      .num_o(num_c[g+1]), .den_o(den_c[g+1]), .quo_o(quo_c[g+1])
    );
  end

  assign quo_o   = quo_c[DIV_STEPS];
  // round half away: 2*rem >= den
  assign round_o = ({num_c[DIV_STEPS], 1'b0} >= {{(NUM_W+1-DEN_W){1'b0}}, den_c[DIV_STEPS]});
endmodule

@@ rtl/perspective_world_to_screen.sv @@
// Perspective world-to-screen projection, one point per cycle while the output is not stalled.
// The pipe has 26 register stages: products, dot sums, numerators, scale multiply,
// a 21-cell division chain per axis and the output register.
// The whole pipe advances only when the output register is free or being taken.
// Synchronous active-low reset clears valids; rows reset to zero, viewport 640x480.
module perspective_world_to_screen #(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [23:0] in_world_x,
  input  logic signed [23:0] in_world_y,
  input  logic signed [23:0] in_world_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_visible,
  output logic signed [19:0] out_screen_x,
  output logic signed [19:0] out_screen_y,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import pwts_pkg::*;

  localparam int PW    = COEF_WIDTH + COORD_WIDTH;      // product width
  localparam int DW    = PW + 3;                        // dot-product width
  localparam int NUMW  = DW + 1;                        // w+cx magnitude
  localparam int KNUMW = NUMW + DIM_W + 3;              // times 8*W
  localparam int LAT   = 3 + 1 + DIV_STEPS + 1;

  logic [63:0] row_x_r, row_y_r, row_w_r;
  logic [DIM_W-1:0] width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= '0; row_y_r <= '0; row_w_r <= '0;
      width_r <= DIM_W'(640); height_r <= DIM_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_X:  row_x_r  <= cfg_data;
        REG_ROW_Y:  row_y_r  <= cfg_data;
        REG_ROW_W:  row_w_r  <= cfg_data;
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic adv;
  logic [LAT-1:0] vld_r;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
  end
  assign out_valid = vld_r[LAT-1];

  function automatic logic signed [COEF_WIDTH-1:0] cf(input logic [63:0] row, input int s);
    cf = row[s*COEF_SLOT +: COEF_WIDTH];
  endfunction

  // stage 1: nine products plus offsets
  logic signed [COORD_WIDTH-1:0] x, y, z;
  assign x = COORD_WIDTH'($unsigned(in_world_x));
  assign y = COORD_WIDTH'($unsigned(in_world_y));
  assign z = COORD_WIDTH'($unsigned(in_world_z));

  logic signed [PW-1:0] p_r [3][3];
  logic signed [PW-1:0] o_r [3];
  logic [63:0] rows [3];
  assign rows[0] = row_x_r;
  assign rows[1] = row_y_r;
  assign rows[2] = row_w_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        p_r[r][0] <= PW'(cf(rows[r], 0) * x);
        p_r[r][1] <= PW'(cf(rows[r], 1) * y);
        p_r[r][2] <= PW'(cf(rows[r], 2) * z);
        o_r[r]    <= PW'(cf(rows[r], 3)) <<< COORD_FRAC;
      end
    end
  end

  // stage 2: dot products
  logic signed [DW-1:0] d_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++)
        d_r[r] <= DW'(p_r[r][0]) + DW'(p_r[r][1]) + DW'(p_r[r][2]) + DW'(o_r[r]);
    end
  end

  // stage 3: numerators, visibility
  logic signed [NUMW-1:0] tx, ty;
  logic [NUMW-1:0] mx_r, my_r;
  logic [DW-1:0] den3_r;
  side_t s3_r;
  always_comb begin
    tx = NUMW'(d_r[2]) + NUMW'(d_r[0]);
    ty = NUMW'(d_r[2]) - NUMW'(d_r[1]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r   <= tx[NUMW-1] ? NUMW'(-tx) : NUMW'(tx);
      my_r   <= ty[NUMW-1] ? NUMW'(-ty) : NUMW'(ty);
      den3_r <= d_r[2];
      s3_r.vis   <= (d_r[2] >= DW'(W_VIS_MIN));
      s3_r.neg_x <= tx[NUMW-1];
      s3_r.neg_y <= ty[NUMW-1];
      s3_r.zx    <= (width_r == '0);
      s3_r.zy    <= (height_r == '0);
    end
  end

  // stage 4: scale by 8*dimension (exact quotient of k*t/w)
  logic [KNUMW-1:0] nx_r, ny_r;
  logic [DW-1:0] den4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r   <= KNUMW'(mx_r) * KNUMW'({width_r, 3'b000});
      ny_r   <= KNUMW'(my_r) * KNUMW'({height_r, 3'b000});
      den4_r <= s3_r.vis ? den3_r : DW'(1);
    end
  end

  // saturate quotient at 2^20 before dividing: clamp numerator
  logic [KNUMW-1:0] cx_num, cy_num, lim;
  assign lim    = KNUMW'(den4_r) << (QUO_W-1);
  assign cx_num = (nx_r >= lim) ? lim : nx_r;
  assign cy_num = (ny_r >= lim) ? lim : ny_r;

  logic [QUO_W-1:0] qx, qy;
  logic rx, ry;
  pwts_divider #(.NUM_W(KNUMW), .DEN_W(DW)) u_div_x (
    .clk(clk), .en(adv), .num_i(cx_num), .den_i(den4_r), .quo_o(qx), .round_o(rx));
  pwts_divider #(.NUM_W(KNUMW), .DEN_W(DW)) u_div_y (
    .clk(clk), .en(adv), .num_i(cy_num), .den_i(den4_r), .quo_o(qy), .round_o(ry));

  // side data delayed alongside the division chain
  side_t side_d [DIV_STEPS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= s3_r;
      for (int i = 1; i <= DIV_STEPS; i++) side_d[i] <= side_d[i-1];
    end
  end
  side_t sf;
  assign sf = side_d[DIV_STEPS];

  // final: round, sign, saturate
  logic [QUO_W:0] tot_x, tot_y;
  logic sat_x, sat_y;
  logic signed [OUT_W-1:0] fx, fy;
  always_comb begin
    tot_x = {1'b0, qx} + (QUO_W+1)'(rx);
    tot_y = {1'b0, qy} + (QUO_W+1)'(ry);
    sat_x = 1'b0; sat_y = 1'b0;
    if (sf.zx) fx = '0;
    else if (sf.neg_x) begin
      if (tot_x > (QUO_W+1)'(524288)) begin fx = OUT_W'(-524288); sat_x = 1'b1; end
      else fx = OUT_W'(-tot_x);
    end else begin
      if (tot_x > (QUO_W+1)'(524287)) begin fx = OUT_W'(524287); sat_x = 1'b1; end
      else fx = OUT_W'(tot_x);
    end
    if (sf.zy) fy = '0;
    else if (sf.neg_y) begin
      if (tot_y > (QUO_W+1)'(524288)) begin fy = OUT_W'(-524288); sat_y = 1'b1; end
      else fy = OUT_W'(-tot_y);
    end else begin
      if (tot_y > (QUO_W+1)'(524287)) begin fy = OUT_W'(524287); sat_y = 1'b1; end
      else fy = OUT_W'(tot_y);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_visible   <= sf.vis;
      out_screen_x  <= sf.vis ? fx : '0;
      out_screen_y  <= sf.vis ? fy : '0;
      out_saturated <= sf.vis && (sat_x || sat_y);
    end
  end

`ifndef SYNTHESIS
  a_zero_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_screen_x == '0 && out_screen_y == '0 && !out_saturated)
    else $error("hidden point with nonzero output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_screen_x))
    else $error("result dropped under stall");
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without back-pressure");
`endif
endmodule
